[rtl/core/ked_pkg.sv]
// shared types, constants and lookup functions for the keypad event decoder
`default_nettype none

package ked_pkg;

    // event kinds of an input word
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_BARCODE = 2'd2;

    // result kinds
    localparam logic [1:0] RES_NOTHING   = 2'd0;
    localparam logic [1:0] RES_KEYSTROKE = 2'd1;
    localparam logic [1:0] RES_BARCODE   = 2'd2;

    // command codes
    localparam logic [3:0] CMD_START_AGAIN = 4'd0;
    localparam logic [3:0] CMD_UP          = 4'd1;
    localparam logic [3:0] CMD_PREVIOUS    = 4'd2;
    localparam logic [3:0] CMD_DOWN        = 4'd3;
    localparam logic [3:0] CMD_NEXT        = 4'd4;
    localparam logic [3:0] CMD_SELECT      = 4'd5;
    localparam logic [3:0] CMD_UNDO        = 4'd6;
    localparam logic [3:0] CMD_FINISH      = 4'd7;
    localparam logic [3:0] CMD_VOL_DOWN    = 4'd8;
    localparam logic [3:0] CMD_VOL_UP      = 4'd9;
    localparam logic [3:0] CMD_UNUSED      = 4'd10;

    localparam logic [7:0] LEFT_SHIFT_CODE = 8'd50;

    localparam int SEQ_LEN   = 8;
    localparam int CHORD_LEN = 3;

    typedef logic [7:0] key_t;
    typedef logic [SEQ_LEN-1:0][7:0] seq_t;
    typedef logic [CHORD_LEN-1:0][7:0] chord_keys_t;

    // entry 0 is the oldest key of the sequence
    localparam seq_t RESET_SEQ =
        {8'h59, 8'h59, 8'h59, 8'h13, 8'h13, 8'h59, 8'h59, 8'h59};
    localparam seq_t SHUTDOWN_SEQ =
        {8'h13, 8'h13, 8'h13, 8'h59, 8'h59, 8'h13, 8'h13, 8'h13};

    // entry 0 sits in the low byte
    localparam chord_keys_t RESET_CHORD    = {8'h57, 8'h51, 8'h54};
    localparam chord_keys_t SHUTDOWN_CHORD = {8'h59, 8'h4F, 8'h54};

    // chord mark control between the top level and a chord tracker
    typedef struct packed {
        logic press;
        logic release_key;
        logic clear;
    } chord_ctl_t;

    // one result word
    typedef struct packed {
        logic [1:0] result_kind;
        logic [3:0] command;
        logic       reset_request;
        logic       shutdown_request;
    } result_t;

    // second keypad style to first style; bit 8 flags a remapped code
    function automatic logic [8:0] remap_code(input logic [7:0] code, input logic shift);
        logic [8:0] r;
        begin
            case (code)
                8'h0a:   r = {1'b1, 8'h4d};
                8'h0b:   r = {1'b1, 8'h50};
                8'h0d:   r = {1'b1, 8'h53};
                8'h0e:   r = {1'b1, 8'h5a};
                8'h0f:   r = {1'b1, 8'h55};
                8'h10:   r = {1'b1, 8'h6a};
                8'h11:   r = shift ? {1'b1, 8'h16} : {1'b1, 8'h58};
                8'h12:   r = {1'b1, 8'h3f};
                8'h0c:   r = shift ? {1'b1, 8'h68} : {1'b1, 8'h59};
                8'h13:   r = {1'b1, 8'h13};
                default: r = {1'b0, code};
            endcase
            return r;
        end
    endfunction

    // key to command
    function automatic logic [3:0] map_command(input logic [7:0] code);
        logic [3:0] c;
        begin
            case (code)
                8'h4d:   c = CMD_START_AGAIN;
                8'h50:   c = CMD_UP;
                8'h53:   c = CMD_PREVIOUS;
                8'h58:   c = CMD_DOWN;
                8'h55:   c = CMD_NEXT;
                8'h5a:   c = CMD_SELECT;
                8'h16:   c = CMD_UNDO;
                8'h68:   c = CMD_FINISH;
                8'h6a:   c = CMD_VOL_DOWN;
                8'h3f:   c = CMD_VOL_UP;
                default: c = CMD_UNUSED;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/keypad_event_decoder_core.sv]
// keypad event decoder top level: history cell chain, chord trackers, output buffer
`default_nettype none

// Decodes one keypad event per word and returns one result word for each.
// An event is taken in the cycle it is offered if input ready is high; its
// result is registered in output or skid, so one word per clock is sustained
// while the output side keeps up. A two-entry output buffer (output register
// plus skid register) lets one more word in while a result waits; input ready
// drops only when both entries hold words. The key history is a chain of
// HISTORY_DEPTH cells; the newest key enters the last cell and every cell
// hands its key to its older neighbor on each remapped press. The newest
// eight cells are compared against the reset and shutdown sequences in the
// same cycle. A reset or shutdown request clears the history and the chord
// marks. No clearing pass is needed after reset.

module keypad_event_decoder_core #(
    parameter int HISTORY_DEPTH = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] event_kind,
    input  wire logic [7:0] key_code,
    input  wire logic       shift_held,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      result_kind,
    output logic [3:0]      command,
    output logic            reset_request,
    output logic            shutdown_request
);

    localparam int FIRST_WATCHED = HISTORY_DEPTH - ked_pkg::SEQ_LEN;

    logic                    accept;
    logic                    take;
    logic                    is_press;
    logic                    is_release;
    logic                    is_barcode;
    logic [8:0]              remapped;
    logic                    was_remapped;
    logic [7:0]              code;
    logic                    shift_en;
    logic                    hist_clear;
    logic                    seq_rst;
    logic                    seq_shd;
    logic                    rst_full;
    logic                    shd_full;
    logic                    rst_req;
    logic                    shd_req;
    ked_pkg::chord_ctl_t     chord_ctl;
    ked_pkg::result_t        result;
    ked_pkg::result_t        out_reg;
    ked_pkg::result_t        out_next;
    ked_pkg::result_t        skid_reg;
    ked_pkg::result_t        skid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic [7:0]              cell_in  [HISTORY_DEPTH];
    logic [7:0]              cell_out [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] rst_hits;
    logic [HISTORY_DEPTH-1:0] shd_hits;

    // handshakes
    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    // event decode and keypad style remap
    assign is_press     = (event_kind == ked_pkg::KIND_PRESS);
    assign is_release   = (event_kind == ked_pkg::KIND_RELEASE);
    assign is_barcode   = (event_kind == ked_pkg::KIND_BARCODE);
    assign remapped     = ked_pkg::remap_code(key_code, shift_held);
    assign was_remapped = remapped[8];
    assign code         = remapped[7:0];

    assign shift_en = accept && is_press && was_remapped;

    // history cell chain, cell 0 oldest
    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_cell
        localparam int SEQ_POS = (i >= FIRST_WATCHED) ? (i - FIRST_WATCHED) : 0;

        if (i == HISTORY_DEPTH - 1)
        begin : g_head
            assign cell_in[i] = code;
        end
        else
        begin : g_link
            assign cell_in[i] = cell_out[i+1];
        end

        ked_hist_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .clear    (hist_clear),
            .data_in  (cell_in[i]),
            .watch    (i >= FIRST_WATCHED),
            .rst_key  (ked_pkg::RESET_SEQ[SEQ_POS]),
            .shd_key  (ked_pkg::SHUTDOWN_SEQ[SEQ_POS]),
            .data_out (cell_out[i]),
            .rst_hit  (rst_hits[i]),
            .shd_hit  (shd_hits[i])
        );
    end

    // sequence matches only count on a remapped press
    assign seq_rst = was_remapped && (&rst_hits);
    assign seq_shd = was_remapped && (&shd_hits);

    // chord trackers
    assign chord_ctl.press       = accept && is_press;
    assign chord_ctl.release_key = accept && is_release;
    assign chord_ctl.clear       = hist_clear;

    ked_chord u_rst_chord (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (chord_ctl),
        .code  (code),
        .keys  (ked_pkg::RESET_CHORD),
        .full  (rst_full)
    );

    ked_chord u_shd_chord (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (chord_ctl),
        .code  (code),
        .keys  (ked_pkg::SHUTDOWN_CHORD),
        .full  (shd_full)
    );

    // requests, reset over shutdown
    assign rst_req    = is_press && (seq_rst || rst_full);
    assign shd_req    = is_press && !rst_req && (seq_shd || shd_full);
    assign hist_clear = accept && (rst_req || shd_req);

    // result word
    always_comb
    begin
        result.result_kind      = ked_pkg::RES_NOTHING;
        result.command          = ked_pkg::CMD_UNUSED;
        result.reset_request    = rst_req;
        result.shutdown_request = shd_req;
        if (is_press)
        begin
            if (!rst_req && !shd_req && (code != ked_pkg::LEFT_SHIFT_CODE))
            begin
                result.result_kind = ked_pkg::RES_KEYSTROKE;
                result.command     = ked_pkg::map_command(code);
            end
        end
        else if (is_barcode)
        begin
            result.result_kind = ked_pkg::RES_BARCODE;
        end
    end

    // output register with skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_reg.result_kind;
    assign command          = out_reg.command;
    assign reset_request    = out_reg.reset_request;
    assign shutdown_request = out_reg.shutdown_request;

endmodule

`default_nettype wire

[rtl/core/ked_hist_cell.sv]
// one history cell: holds a key, takes its neighbor's key on a shift, flags pattern hits
`default_nettype none

module ked_hist_cell (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         shift_en,
    input  wire logic         clear,
    input  wire logic [7:0]   data_in,
    input  wire logic         watch,
    input  wire logic [7:0]   rst_key,
    input  wire logic [7:0]   shd_key,
    output logic [7:0]        data_out,
    output logic              rst_hit,
    output logic              shd_hit
);

    logic [7:0] val_reg;
    logic [7:0] val_next;

    // hits look at the key this cell holds after the shift
    assign rst_hit = !watch || (data_in == rst_key);
    assign shd_hit = !watch || (data_in == shd_key);
    assign data_out = val_reg;

    // clear wins over shift
    always_comb
    begin
        val_next = val_reg;
        if (clear)
        begin
            val_next = 8'h00;
        end
        else if (shift_en)
        begin
            val_next = data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= 8'h00;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ked_chord.sv]
// three-key chord tracker: press and release marks
`default_nettype none

module ked_chord (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ked_pkg::chord_ctl_t  ctl,
    input  wire logic [7:0]           code,
    input  wire ked_pkg::chord_keys_t keys,
    output logic                      full
);

    logic [ked_pkg::CHORD_LEN-1:0] marks_reg;
    logic [ked_pkg::CHORD_LEN-1:0] marks_next;
    logic [ked_pkg::CHORD_LEN-1:0] hit;
    logic [ked_pkg::CHORD_LEN-1:0] set_marks;

    // which chord keys the code names
    always_comb
    begin
        for (int i = 0; i < ked_pkg::CHORD_LEN; i++)
        begin
            hit[i] = (keys[i] == code);
        end
    end

    // chord complete once this press is marked
    assign set_marks = marks_reg | hit;
    assign full = &set_marks;

    always_comb
    begin
        marks_next = marks_reg;
        if (ctl.clear)
        begin
            marks_next = '0;
        end
        else if (ctl.press)
        begin
            marks_next = set_marks;
        end
        else if (ctl.release_key)
        begin
            marks_next = marks_reg & ~hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

endmodule

`default_nettype wire
